// ===== rtl/bcc_pkg.sv =====
package bcc_pkg;

    typedef enum logic [1:0] {
        KIND_PIN  = 2'd0,
        KIND_POLL = 2'd1,
        KIND_LONG = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_PRESSED = 3'b010,
        PH_AWAIT   = 3'b100
    } phase_t;

    localparam logic REG_DEBOUNCE     = 1'b0;
    localparam logic REG_DOUBLE_CLICK = 1'b1;

    localparam int CFG_W = 16;
    localparam int TIME_W = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   press_start;
        logic [TIME_W-1:0]   last_release;
        logic                release_seen;
        logic [TIME_W-1:0]   last_accept;
        logic                last_level;
        event_t              pending_event;
        logic                event_ready;
    } state_t;

endpackage

// ===== rtl/button_click_classifier.sv =====
// button click classifier
// input channel: in_valid/in_ready with kind, now_ms, pin_level and
// long_press_ms; kind selects a pin sample, an event poll or a long-press
// check. every input word gives exactly one output word on
// out_valid/out_ready carrying event_res and long_handled.
// configuration: cfg_we writes cfg_data into debounce_ms (index 0) or
// double_click_ms (index 1); write only while the block is idle.
// path: a word taken on the input is held in the input register, then
// classified by bcc_step and stored with the new state in the output register.
// throughput: one word per cycle while out_ready is high; the input register and the output register
// form a two-deep pipe, and the state update of one word is a single compare,
// subtract and select pass, so the next word sees it right away.
// stall: when out_ready is low the output word holds, one more word waits in
// the input register, then in_ready drops until the output is taken.
// reset: both stages empty, debounce 50 ms, double-click window 300 ms,
// phase idle, pin level released, no event pending, all times zero.
module button_click_classifier (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic [bcc_pkg::TIME_W-1:0]      now_ms,
    input  logic                            pin_level,
    input  logic [bcc_pkg::CFG_W-1:0]       long_press_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      event_res,
    output logic                            long_handled,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]       cfg_data
);

    logic [bcc_pkg::CFG_W-1:0]      debounce_reg;
    logic [bcc_pkg::CFG_W-1:0]      double_click_reg;

    logic                           in_valid_reg;
    bcc_pkg::kind_t                 kind_reg;
    logic [bcc_pkg::TIME_W-1:0]     now_reg;
    logic                           level_reg;
    logic [bcc_pkg::CFG_W-1:0]      thr_reg;

    logic                           out_valid_reg;
    bcc_pkg::event_t                event_reg;
    logic                           long_reg;

    bcc_pkg::state_t                state_reg;
    bcc_pkg::state_t                state_next;
    bcc_pkg::event_t                event_next;
    logic                           long_next;

    logic                           advance;
    logic                           in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign long_handled = long_reg;

    bcc_step u_step (
        .st              (state_reg),
        .kind            (kind_reg),
        .now_ms          (now_reg),
        .pin_level       (level_reg),
        .long_press_ms   (thr_reg),
        .debounce_ms     (debounce_reg),
        .double_click_ms (double_click_reg),
        .st_next         (state_next),
        .event_res       (event_next),
        .long_handled    (long_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= bcc_pkg::DEBOUNCE_RESET;
            double_click_reg <= bcc_pkg::DOUBLE_CLICK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == bcc_pkg::REG_DEBOUNCE)
            begin
                debounce_reg <= cfg_data;
            end
            if (cfg_index == bcc_pkg::REG_DOUBLE_CLICK)
            begin
                double_click_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.phase         <= bcc_pkg::PH_IDLE;
            state_reg.press_start   <= '0;
            state_reg.last_release  <= '0;
            state_reg.release_seen  <= 1'b0;
            state_reg.last_accept   <= '0;
            state_reg.last_level    <= 1'b1;
            state_reg.pending_event <= bcc_pkg::EV_NONE;
            state_reg.event_ready   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= bcc_pkg::kind_t'(kind);
            now_reg   <= now_ms;
            level_reg <= pin_level;
            thr_reg   <= long_press_ms;
        end
        if (advance)
        begin
            event_reg <= event_next;
            long_reg  <= long_next;
        end
    end

    a_long_only_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && long_handled) |-> (event_res == bcc_pkg::EV_NONE))
        else $error("long press flag together with an event code");

    a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg == bcc_pkg::KIND_POLL)) |=> !state_reg.event_ready)
        else $error("event still ready after a poll");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty output stage");

    a_event_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (kind_reg != bcc_pkg::KIND_POLL)) |=> (event_res == bcc_pkg::EV_NONE))
        else $error("event code on a word that is not a poll");

endmodule

// ===== rtl/bcc_step.sv =====
module bcc_step (
    input  bcc_pkg::state_t                 st,
    input  bcc_pkg::kind_t                  kind,
    input  logic [bcc_pkg::TIME_W-1:0]      now_ms,
    input  logic                            pin_level,
    input  logic [bcc_pkg::CFG_W-1:0]       long_press_ms,
    input  logic [bcc_pkg::CFG_W-1:0]       debounce_ms,
    input  logic [bcc_pkg::CFG_W-1:0]       double_click_ms,
    output bcc_pkg::state_t                 st_next,
    output bcc_pkg::event_t                 event_res,
    output logic                            long_handled
);

    logic [bcc_pkg::TIME_W-1:0] since_accept;
    logic [bcc_pkg::TIME_W-1:0] since_release;
    logic [bcc_pkg::TIME_W-1:0] since_press;
    logic                       debounced;
    logic                       in_window;
    logic                       held_long;

    assign since_accept  = now_ms - st.last_accept;
    assign since_release = now_ms - st.last_release;
    assign since_press   = now_ms - st.press_start;

    assign debounced = since_accept >= {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, debounce_ms};
    assign in_window = since_release < {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, double_click_ms};
    assign held_long = since_press >= {{(bcc_pkg::TIME_W-bcc_pkg::CFG_W){1'b0}}, long_press_ms};

    always_comb
    begin
        st_next      = st;
        event_res    = bcc_pkg::EV_NONE;
        long_handled = 1'b0;
        case (kind)
            bcc_pkg::KIND_PIN:
            begin
                if (debounced && (pin_level != st.last_level))
                begin
                    st_next.last_accept = now_ms;
                    st_next.last_level  = pin_level;
                    if (!pin_level)
                    begin
                        st_next.press_start = now_ms;
                        st_next.phase       = bcc_pkg::PH_PRESSED;
                    end
                    else if (st.release_seen && in_window)
                    begin
                        st_next.pending_event = bcc_pkg::EV_DOUBLE;
                        st_next.event_ready   = 1'b1;
                        st_next.phase         = bcc_pkg::PH_IDLE;
                    end
                    else if (st.phase != bcc_pkg::PH_IDLE)
                    begin
                        st_next.phase        = bcc_pkg::PH_AWAIT;
                        st_next.last_release = now_ms;
                        st_next.release_seen = 1'b1;
                    end
                end
            end
            bcc_pkg::KIND_POLL:
            begin
                // expired single click, else the ready event, goes out
                if ((st.phase == bcc_pkg::PH_AWAIT) && !in_window)
                begin
                    event_res     = bcc_pkg::EV_SINGLE;
                    st_next.phase = bcc_pkg::PH_IDLE;
                end
                else if (st.event_ready)
                begin
                    event_res = st.pending_event;
                end
                st_next.pending_event = bcc_pkg::EV_NONE;
                st_next.event_ready   = 1'b0;
            end
            bcc_pkg::KIND_LONG:
            begin
                if ((st.phase == bcc_pkg::PH_PRESSED) && held_long)
                begin
                    st_next.pending_event = bcc_pkg::EV_LONG;
                    st_next.event_ready   = 1'b1;
                    st_next.phase         = bcc_pkg::PH_IDLE;
                    long_handled          = 1'b1;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule
